// File: rtl/bmma_pkg.sv
// shared types, codes and value helpers for the binned min/max aggregator
package bmma_pkg;

   // item kinds carried on req_tuser
   localparam logic [1:0] KIND_ACCUM = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // register indexes on the csr port
   localparam logic [1:0] CSR_MODE_MAX   = 2'd0;
   localparam logic [1:0] CSR_NUM_FORMAT = 2'd1;
   localparam logic [1:0] CSR_SWAP_BYTES = 2'd2;

   // field widths
   localparam int VALUE_W = 64;
   localparam int INDEX_W = 10;

   // epoch tag kept beside each bin; tag zero never matches a live epoch
   localparam int EPOCH_W = 8;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};
   localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;

   // ieee double masks
   localparam logic [63:0] SIGN64    = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAG64     = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] EXP_MASK  = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;

   typedef logic [VALUE_W-1:0] value_type;

   // reverse the eight bytes of a word
   function automatic value_type reverse_bytes(input value_type v);
      value_type r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         r[8*i +: 8] = v[8*(7-i) +: 8];
      end
      return r;
   endfunction

   // true for a double nan (exponent all ones, fraction nonzero)
   function automatic logic is_nan(input value_type v);
      return ((v & EXP_MASK) == EXP_MASK) && ((v & FRAC_MASK) != '0);
   endfunction

   // value that an untouched bin stands for
   function automatic value_type bin_fill(input logic is_double, input logic keep_max);
      value_type f;
      if (is_double) begin
         f = keep_max ? (SIGN64 | EXP_MASK) : EXP_MASK;
      end else begin
         f = keep_max ? SIGN64 : MAG64;
      end
      return f;
   endfunction

   // unsigned key with the same order as the numeric value; both zeros map alike
   function automatic value_type order_key(input value_type v, input logic is_double);
      value_type z;
      value_type k;
      if (is_double) begin
         z = ((v & MAG64) == '0) ? '0 : v;
         k = z[63] ? ~z : (z ^ SIGN64);
      end else begin
         k = v ^ SIGN64;
      end
      return k;
   endfunction

endpackage

// File: rtl/bmma_ram.sv
// simple dual port ram with one write port and a registered read port
module bmma_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/binned_min_max_aggregator_unit.sv
// binned min/max aggregator: per-bin running extreme kept in one tagged ram
//
//   channel  dir  handshake             payload
//   req      in   req_tvalid/tready     tdata: bin_index, sample, selected; tuser: kind
//   rsp      out  rsp_tvalid/tready     tdata: result_value, bin_touched
//   csr      in   csr_wr_en             csr_index, csr_wdata (no read-back)
//
// one item per cycle while req is ready: accept issues the ram read, the next
// cycle merges and writes back, with the previous write forwarded on a same-bin hit.
// a read result passes from stage one into the output buffer before it is offered;
// req stalls while the two-word output buffer would be full after this edge.
// after reset a clearing pass writes epoch tag zero into all NUM_BINS entries
// (no items taken meanwhile); a clear bumps the epoch, and every 255th clear
// stalls req while it sits in stage one and then repeats the clearing pass.
module binned_min_max_aggregator_unit #(
   parameter int NUM_BINS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // [9:0] bin_index, [73:10] sample, [74] selected
   input  logic [1:0]  req_tuser,   // [1:0] kind
   // response side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [63:0] result_value, [64] bin_touched
   // register writes
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [0:0]  csr_wdata
);

   localparam int AW     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int VW     = bmma_pkg::VALUE_W;
   localparam int EW     = bmma_pkg::EPOCH_W;
   localparam int MEM_W  = VW + EW;
   localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BINS - 1);

   // configuration registers
   logic mode_max_ff;
   logic num_format_ff;
   logic swap_bytes_ff;

   // control state
   logic          sweep_busy_ff;
   logic [AW-1:0] sweep_addr_ff;
   logic [EW-1:0] epoch_ff;

   // stage one (ram data arrives here)
   logic          s1_valid_ff;
   logic [1:0]    s1_kind_ff;
   logic [AW-1:0] s1_addr_ff;
   logic          s1_in_range_ff;
   logic          s1_use_ff;
   logic [VW-1:0] s1_value_ff;

   // last accumulate write, for forwarding
   logic          wr_valid_ff;
   logic [AW-1:0] wr_addr_ff;
   logic [MEM_W-1:0] wr_word_ff;

   // output buffer: head and skid
   logic          rsp_valid_ff;
   logic [VW-1:0] rsp_value_ff;
   logic          rsp_touched_ff;
   logic          skid_valid_ff;
   logic [VW-1:0] skid_value_ff;
   logic          skid_touched_ff;

   // request fields
   logic [1:0]          in_kind;
   logic [bmma_pkg::INDEX_W-1:0] in_index;
   logic [VW-1:0]       in_sample;
   logic                in_selected;
   logic [VW-1:0]       in_value;
   logic [AW+9:0]       in_index_wide;
   logic [AW-1:0]       in_addr;
   logic                in_range;
   logic                accept;

   assign in_kind       = req_tuser;
   assign in_index      = req_tdata[9:0];
   assign in_sample     = req_tdata[73:10];
   assign in_selected   = req_tdata[74];
   assign in_value      = swap_bytes_ff ? bmma_pkg::reverse_bytes(in_sample) : in_sample;
   assign in_index_wide = (AW + 10)'(in_index);
   assign in_addr       = in_index_wide[AW-1:0];
   assign in_range      = (32'(in_index) < 32'(NUM_BINS));
   assign accept        = req_tvalid && req_tready;

   // ram
   logic             mem_wr_en;
   logic [AW-1:0]    mem_wr_addr;
   logic [MEM_W-1:0] mem_wr_data;
   logic [MEM_W-1:0] mem_rd_data;

   bmma_ram #(
      .WIDTH (MEM_W),
      .DEPTH (NUM_BINS)
   ) u_bin_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (accept),
      .rd_addr (in_addr),
      .rd_data (mem_rd_data)
   );

   // stage one merge
   logic [MEM_W-1:0] stored_word;
   logic             stored_valid;
   logic [VW-1:0]    fill;
   logic [VW-1:0]    stored_value;
   logic [VW-1:0]    key_new;
   logic [VW-1:0]    key_old;
   logic             take_new;
   logic [VW-1:0]    merged;
   logic             acc_write;
   logic             s1_read;
   logic             s1_clear;
   logic             push;
   logic [VW-1:0]    push_value;
   logic             push_touched;

   always_comb begin
      stored_word  = (wr_valid_ff && (wr_addr_ff == s1_addr_ff)) ? wr_word_ff : mem_rd_data;
      stored_valid = (stored_word[MEM_W-1:VW] == epoch_ff);
      fill         = bmma_pkg::bin_fill(num_format_ff, mode_max_ff);
      stored_value = stored_valid ? stored_word[VW-1:0] : fill;
      key_new      = bmma_pkg::order_key(s1_value_ff, num_format_ff);
      key_old      = bmma_pkg::order_key(stored_value, num_format_ff);
      take_new     = mode_max_ff ? (key_new >= key_old) : (key_new <= key_old);
      merged       = take_new ? s1_value_ff : stored_value;
      acc_write    = s1_valid_ff && (s1_kind_ff == bmma_pkg::KIND_ACCUM)
                     && s1_in_range_ff && s1_use_ff;
      s1_read      = s1_valid_ff && (s1_kind_ff == bmma_pkg::KIND_READ);
      s1_clear     = s1_valid_ff && (s1_kind_ff == bmma_pkg::KIND_CLEAR);
      push         = s1_read;
      push_touched = s1_in_range_ff && stored_valid;
      push_value   = push_touched ? stored_word[VW-1:0] : fill;
   end

   // ram write: sweep or accumulate write-back
   always_comb begin
      if (sweep_busy_ff) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = sweep_addr_ff;
         mem_wr_data = {bmma_pkg::EPOCH_NONE, {VW{1'b0}}};
      end else begin
         mem_wr_en   = acc_write;
         mem_wr_addr = s1_addr_ff;
         mem_wr_data = {epoch_ff, merged};
      end
   end

   // ready: no sweep, no wrapping clear in flight, room for a result
   logic       pop;
   logic [1:0] slots;
   logic [1:0] room_limit;

   assign pop        = rsp_valid_ff && rsp_tready;
   assign slots      = 2'(rsp_valid_ff) + 2'(skid_valid_ff) + 2'(s1_read);
   assign room_limit = 2'd1 + 2'(pop);
   assign req_tready = !sweep_busy_ff
                       && !(s1_clear && (epoch_ff == bmma_pkg::EPOCH_LAST))
                       && (slots <= room_limit);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_max_ff   <= 1'b1;
         num_format_ff <= 1'b1;
         swap_bytes_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            bmma_pkg::CSR_MODE_MAX:   mode_max_ff   <= csr_wdata[0];
            bmma_pkg::CSR_NUM_FORMAT: num_format_ff <= csr_wdata[0];
            bmma_pkg::CSR_SWAP_BYTES: swap_bytes_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // epoch and clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_busy_ff <= 1'b1;
         sweep_addr_ff <= '0;
         epoch_ff      <= bmma_pkg::EPOCH_FIRST;
      end else if (sweep_busy_ff) begin
         if (sweep_addr_ff == LAST_ADDR) begin
            sweep_busy_ff <= 1'b0;
         end
         sweep_addr_ff <= sweep_addr_ff + AW'(1);
      end else if (s1_clear) begin
         if (epoch_ff == bmma_pkg::EPOCH_LAST) begin
            sweep_busy_ff <= 1'b1;
            sweep_addr_ff <= '0;
            epoch_ff      <= bmma_pkg::EPOCH_FIRST;
         end else begin
            epoch_ff <= epoch_ff + EW'(1);
         end
      end
   end

   // stage one control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wr_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         wr_valid_ff <= acc_write && !sweep_busy_ff;
      end
   end

   // stage one and forwarding payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff     <= in_kind;
         s1_addr_ff     <= in_addr;
         s1_in_range_ff <= in_range;
         s1_use_ff      <= in_selected && !(num_format_ff && bmma_pkg::is_nan(in_value));
         s1_value_ff    <= in_value;
      end
      if (acc_write) begin
         wr_addr_ff <= s1_addr_ff;
         wr_word_ff <= {epoch_ff, merged};
      end
   end

   // output buffer valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || pop) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= push;
         end else begin
            rsp_valid_ff  <= push;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // output buffer payload
   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || pop) begin
         if (skid_valid_ff) begin
            rsp_value_ff    <= skid_value_ff;
            rsp_touched_ff  <= skid_touched_ff;
            skid_value_ff   <= push_value;
            skid_touched_ff <= push_touched;
         end else begin
            rsp_value_ff    <= push_value;
            rsp_touched_ff  <= push_touched;
         end
      end else if (push) begin
         skid_value_ff   <= push_value;
         skid_touched_ff <= push_touched;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_touched_ff, rsp_value_ff};

endmodule

// File: bench/tb.sv
// testbench for binned_min_max_aggregator_unit: bin extreme scoreboard and stream drivers
`timescale 1ns / 100ps

module tb;

   // kind code that the block ignores
   localparam logic [1:0] KIND_SPARE = 2'd3;

   // one expected read reply
   typedef struct {
      logic [63:0] value;
      logic        touched;
   } read_reply_type;

   // tracks every bin's extreme and touched mark, queues the replies that reads must return
   class bin_extreme_predictor;
      logic [63:0] extreme [1024];
      bit          live [1024];
      bit          keep_max;
      bit          is_double;
      bit          swap_in;
      read_reply_type pending_reads [$];
      int          mismatches;
      int          reads_checked;
      int          merges;
      int          skips;
      int          clears;

      function new();
         foreach (live[i]) live[i] = 1'b0;
         keep_max  = 1'b1;
         is_double = 1'b1;
         swap_in   = 1'b0;
      endfunction

      function void set_reg(logic [1:0] idx, logic bitval);
         case (idx)
            bmma_pkg::CSR_MODE_MAX:   keep_max  = bitval;
            bmma_pkg::CSR_NUM_FORMAT: is_double = bitval;
            bmma_pkg::CSR_SWAP_BYTES: swap_in   = bitval;
            default: ;
         endcase
      endfunction

      function logic [63:0] byte_flip(logic [63:0] v);
         logic [63:0] r;
         for (int b = 0; b < 8; b++) begin
            r[8*b +: 8] = v[56-8*b +: 8];
         end
         return r;
      endfunction

      // what an untouched bin reads as under the current registers
      function logic [63:0] untouched_value();
         if (is_double) begin
            return keep_max ? (bmma_pkg::SIGN64 | bmma_pkg::EXP_MASK) : bmma_pkg::EXP_MASK;
         end
         return keep_max ? bmma_pkg::SIGN64 : bmma_pkg::MAG64;
      endfunction

      // unsigned rank with numeric order; both double zeros rank alike
      function logic [63:0] rank(logic [63:0] v);
         logic [63:0] z;
         if (!is_double) begin
            return v ^ bmma_pkg::SIGN64;
         end
         z = ((v & bmma_pkg::MAG64) == 64'd0) ? 64'd0 : v;
         return z[63] ? ~z : (z ^ bmma_pkg::SIGN64);
      endfunction

      function void note_fault(string msg);
         mismatches++;
         if (mismatches <= 10) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
         end
      endfunction

      // apply one accepted request word
      function void absorb_item(logic [1:0] kind, logic [9:0] idx, logic [63:0] sample,
                                logic sel);
         logic [63:0] v;
         logic [63:0] held;
         bit          take;
         read_reply_type r;
         case (kind)
            bmma_pkg::KIND_ACCUM: begin
               v = swap_in ? byte_flip(sample) : sample;
               if (!sel || (is_double && v[62:52] == 11'h7FF && v[51:0] != 52'd0)) begin
                  skips++;
               end else begin
                  held = live[idx] ? extreme[idx] : untouched_value();
                  // ties go to the incoming value
                  take = keep_max ? (rank(v) >= rank(held)) : (rank(v) <= rank(held));
                  extreme[idx] = take ? v : held;
                  live[idx] = 1'b1;
                  merges++;
               end
            end
            bmma_pkg::KIND_READ: begin
               r.value   = live[idx] ? extreme[idx] : untouched_value();
               r.touched = live[idx];
               pending_reads.push_back(r);
            end
            bmma_pkg::KIND_CLEAR: begin
               foreach (live[i]) live[i] = 1'b0;
               clears++;
            end
            default: ;
         endcase
      endfunction

      // compare one reply word against the oldest pending read
      function void check_read(logic [63:0] value, logic touched);
         read_reply_type want;
         if (pending_reads.size() == 0) begin
            note_fault($sformatf("reply with no read pending: value %h touched %b",
                                 value, touched));
            return;
         end
         want = pending_reads.pop_front();
         reads_checked++;
         if (value !== want.value || touched !== want.touched) begin
            note_fault($sformatf("expected value %h touched %b, got value %h touched %b",
                                 want.value, want.touched, value, touched));
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;   // [9:0] bin_index, [73:10] sample, [74] selected
   logic [1:0]  req_tuser = '0;   // [1:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // [63:0] result_value, [64] bin_touched
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [0:0]  csr_wdata = '0;

   bin_extreme_predictor scoreboard = new();

   // sender pacing
   int max_gap = 0;
   int burst_left = 0;
   int words_sent = 0;
   logic [9:0] last_bin = '0;

   // receiver pacing
   int stall_pct = 0;
   int stall_run = 0;
   int hold_asks = 0;
   int hold_seen = 0;
   int hold_left = 0;

   // interesting value bits: zeros, infinities, nans, extremes, denormals, ones
   logic [63:0] corner_words [16] = '{
      64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
      64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
      64'h7FF8_0000_0000_0000, 64'h7FF0_0000_0000_0001,
      64'hFFF8_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
      64'h0000_0000_0000_0001, 64'h8000_0000_0000_0001,
      64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000,
      64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
      64'hFFEF_FFFF_FFFF_FFFF, 64'h0010_0000_0000_0000
   };

   binned_min_max_aggregator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // receiver: random stall runs, plus a long hold-off when asked
   always @(negedge clock) begin
      if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_left = 120;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready = 1'b0;
      end else if (stall_run > 0) begin
         stall_run--;
         rsp_tready = 1'b0;
      end else if ($urandom_range(99, 0) < stall_pct) begin
         stall_run = $urandom_range(5, 0);
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   // reply monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         scoreboard.check_read(rsp_tdata[63:0], rsp_tdata[64]);
      end
   end

   // offer one word, held until accepted; entered and left at a falling edge
   task automatic send_word(logic [1:0] kind, logic [9:0] idx, logic [63:0] sample, logic sel);
      int gap;
      if (burst_left == 0) begin
         gap = (max_gap == 0) ? 0 : $urandom_range(max_gap, 0);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(12, 1);
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tdata  = {5'b0, sel, sample, idx};
      req_tuser  = kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      scoreboard.absorb_item(kind, idx, sample, sel);
      words_sent++;
      @(negedge clock);
   endtask

   // drop valid and wait until the block has nothing left in flight
   task automatic drain();
      int waited;
      req_tvalid = 1'b0;
      waited = 0;
      while (scoreboard.pending_reads.size() != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (4) @(negedge clock);
      // a clearing pass may still be running
      waited = 0;
      while (!req_tready && waited < 1200) begin
         @(negedge clock);
         waited++;
      end
   endtask

   task automatic write_reg(logic [1:0] idx, logic bitval);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = bitval;
      @(posedge clock);
      scoreboard.set_reg(idx, bitval);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic configure(logic keep_max, logic is_double, logic swap_in);
      write_reg(bmma_pkg::CSR_MODE_MAX, keep_max);
      write_reg(bmma_pkg::CSR_NUM_FORMAT, is_double);
      write_reg(bmma_pkg::CSR_SWAP_BYTES, swap_in);
   endtask

   // value in its numeric meaning, before any byte swap
   function automatic logic [63:0] pick_value();
      logic [63:0] v;
      case ($urandom_range(9, 0))
         0, 1:    v = {$urandom, $urandom};
         2, 3, 4: v = corner_words[$urandom_range(15, 0)];
         5, 6:    v = {1'($urandom_range(1, 0)), 11'(11'h3F8 + $urandom_range(15, 0)),
                       20'($urandom), 32'($urandom)};
         default: v = 64'($signed($urandom_range(200, 0)) - 32'sd100);
      endcase
      return v;
   endfunction

   // mostly a small window of bins so values pile up, sometimes the same bin again
   function automatic logic [9:0] pick_bin();
      int r;
      r = $urandom_range(99, 0);
      if (r < 55) begin
         last_bin = 10'($urandom_range(7, 0));
      end else if (r < 80) begin
         last_bin = last_bin;
      end else if (r < 95) begin
         last_bin = 10'($urandom_range(1023, 0));
      end else begin
         last_bin = $urandom_range(1, 0) ? 10'd1023 : 10'd0;
      end
      return last_bin;
   endfunction

   task automatic random_words(int count);
      int          r;
      logic [1:0]  kind;
      logic [63:0] v;
      logic [63:0] sample;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99, 0);
         if (r < 60) kind = bmma_pkg::KIND_ACCUM;
         else if (r < 92) kind = bmma_pkg::KIND_READ;
         else if (r < 96) kind = bmma_pkg::KIND_CLEAR;
         else kind = KIND_SPARE;
         v = pick_value();
         if ($urandom_range(9, 0) == 0) begin
            sample = {$urandom, $urandom};
         end else begin
            sample = scoreboard.swap_in ? scoreboard.byte_flip(v) : v;
         end
         send_word(kind, pick_bin(), sample, $urandom_range(99, 0) < 85);
      end
   endtask

   // directed words under the reset settings: max, double, no swap
   task automatic directed_words();
      send_word(bmma_pkg::KIND_READ,  10'd5,    64'd0, 1'b1);
      send_word(bmma_pkg::KIND_ACCUM, 10'd5,    64'h3FF0_0000_0000_0000, 1'b1);
      send_word(bmma_pkg::KIND_ACCUM, 10'd5,    64'h4000_0000_0000_0000, 1'b0);
      send_word(bmma_pkg::KIND_ACCUM, 10'd5,    64'h7FF8_0000_0000_0001, 1'b1);
      send_word(bmma_pkg::KIND_ACCUM, 10'd5,    64'hBFF0_0000_0000_0000, 1'b1);
      send_word(bmma_pkg::KIND_READ,  10'd5,    64'd0, 1'b0);
      // equal zeros of opposite sign: the newer one is kept
      send_word(bmma_pkg::KIND_ACCUM, 10'd7,    64'h0000_0000_0000_0000, 1'b1);
      send_word(bmma_pkg::KIND_ACCUM, 10'd7,    64'h8000_0000_0000_0000, 1'b1);
      send_word(bmma_pkg::KIND_READ,  10'd7,    64'd0, 1'b1);
      // negative nan with every bit set is skipped
      send_word(bmma_pkg::KIND_ACCUM, 10'd1023, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send_word(bmma_pkg::KIND_READ,  10'd1023, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      // infinities at the first bin
      send_word(bmma_pkg::KIND_ACCUM, 10'd0,    64'hFFF0_0000_0000_0000, 1'b1);
      send_word(bmma_pkg::KIND_READ,  10'd0,    64'd0, 1'b1);
      send_word(bmma_pkg::KIND_ACCUM, 10'd0,    64'h7FF0_0000_0000_0000, 1'b1);
      send_word(bmma_pkg::KIND_READ,  10'd0,    64'd0, 1'b1);
      // unused kind is ignored
      send_word(KIND_SPARE,           10'd5,    64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send_word(bmma_pkg::KIND_READ,  10'd5,    64'd0, 1'b1);
      send_word(bmma_pkg::KIND_CLEAR, 10'd0,    64'd0, 1'b0);
      send_word(bmma_pkg::KIND_READ,  10'd5,    64'd0, 1'b0);
      send_word(bmma_pkg::KIND_READ,  10'd0,    64'd0, 1'b0);
   endtask

   // many clears in a row so the bin epoch tag wraps, touching and reading a few bins
   task automatic epoch_wrap_words();
      logic [63:0] v;
      for (int n = 0; n < 256; n++) begin
         send_word(bmma_pkg::KIND_CLEAR, 10'd0, 64'd0, 1'b0);
         if (n % 16 == 0) begin
            v = pick_value();
            send_word(bmma_pkg::KIND_ACCUM, 10'(n / 16),
                      scoreboard.swap_in ? scoreboard.byte_flip(v) : v, 1'b1);
            send_word(bmma_pkg::KIND_READ, 10'($urandom_range(15, 0)), 64'd0, 1'b0);
         end
      end
   endtask

   // main sequence
   initial begin
      logic [2:0] setting;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      drain();
      directed_words();
      drain();

      // every register combination; the block keeps stored bits across changes
      for (int p = 0; p < 8; p++) begin
         setting = 3'(p ^ 1);
         configure(setting[0], setting[1], setting[2]);
         case (p % 3)
            0: begin max_gap = 0; stall_pct = 0; end
            1: begin max_gap = 3; stall_pct = 30; end
            default: begin max_gap = 6; stall_pct = 60; end
         endcase
         // long receiver hold-off while words keep coming
         if (p == 3) begin
            hold_asks++;
         end
         random_words(18);
         drain();
      end

      configure(1'b0, 1'b0, 1'b1);
      max_gap = 2;
      stall_pct = 20;
      epoch_wrap_words();
      drain();

      while (scoreboard.pending_reads.size() != 0) begin
         void'(scoreboard.pending_reads.pop_front());
         scoreboard.note_fault("read never answered");
      end

      $display("run covered %0d words: %0d reads checked, %0d values merged, %0d skipped",
               words_sent, scoreboard.reads_checked, scoreboard.merges, scoreboard.skips);
      $display("all eight register settings, %0d clears through the epoch wrap, %0d mismatches",
               scoreboard.clears, scoreboard.mismatches);
      if (scoreboard.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// File: files.f
rtl/bmma_pkg.sv
rtl/bmma_ram.sv
rtl/binned_min_max_aggregator_unit.sv
bench/tb.sv
